[hw/rtl/pgc_pkg.sv]
// Shared types, constants and helper functions of the pose gesture classifier.
package pgc_pkg;

    localparam int COORD_WIDTH  = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int NUM_POINTS   = 7;
    localparam int IDX_W        = 3;
    localparam int FIELD_W      = 16;
    localparam int DIFF_W       = COORD_WIDTH + 1;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int CW           = PROD_W + 4;
    localparam int ANG_W        = 27;
    localparam int STEP_W       = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam int DEG          = 65536;

    typedef logic [COORD_WIDTH-1:0]   coord_t;
    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef logic signed [ANG_W-1:0]  ang_t;

    typedef struct packed {
        logic start;
        logic missing;
    } ang_req_t;

    typedef struct packed {
        logic done;
        logic busy;
    } ang_rsp_t;

    localparam logic [1:0] ANG_SL = 2'd0;
    localparam logic [1:0] ANG_EL = 2'd1;
    localparam logic [1:0] ANG_SR = 2'd2;
    localparam logic [1:0] ANG_ER = 2'd3;

    localparam logic [IDX_W-1:0] PT_NECK       = 3'd0;
    localparam logic [IDX_W-1:0] PT_L_SHOULDER = 3'd1;
    localparam logic [IDX_W-1:0] PT_L_ELBOW    = 3'd2;
    localparam logic [IDX_W-1:0] PT_L_WRIST    = 3'd3;
    localparam logic [IDX_W-1:0] PT_R_SHOULDER = 3'd4;
    localparam logic [IDX_W-1:0] PT_R_ELBOW    = 3'd5;
    localparam logic [IDX_W-1:0] PT_R_WRIST    = 3'd6;

    localparam ang_t LIM_70  = ANG_W'(70 * DEG);
    localparam ang_t LIM_90  = ANG_W'(90 * DEG);
    localparam ang_t LIM_100 = ANG_W'(100 * DEG);
    localparam ang_t LIM_110 = ANG_W'(110 * DEG);
    localparam ang_t LIM_140 = ANG_W'(140 * DEG);
    localparam ang_t LIM_160 = ANG_W'(160 * DEG);
    localparam ang_t LIM_180 = ANG_W'(180 * DEG);
    localparam ang_t LIM_181 = ANG_W'(181 * DEG);

    // First point, vertex and last point of each of the four angles.
    function automatic logic [IDX_W-1:0] pt_a(input logic [1:0] k);
        logic [IDX_W-1:0] r;
        case (k)
            ANG_SL:  r = PT_NECK;
            ANG_EL:  r = PT_L_SHOULDER;
            ANG_SR:  r = PT_NECK;
            ANG_ER:  r = PT_R_SHOULDER;
            default: r = PT_NECK;
        endcase
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] pt_b(input logic [1:0] k);
        logic [IDX_W-1:0] r;
        case (k)
            ANG_SL:  r = PT_L_SHOULDER;
            ANG_EL:  r = PT_L_ELBOW;
            ANG_SR:  r = PT_R_SHOULDER;
            ANG_ER:  r = PT_R_ELBOW;
            default: r = PT_L_SHOULDER;
        endcase
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] pt_c(input logic [1:0] k);
        logic [IDX_W-1:0] r;
        case (k)
            ANG_SL:  r = PT_L_ELBOW;
            ANG_EL:  r = PT_L_WRIST;
            ANG_SR:  r = PT_R_ELBOW;
            ANG_ER:  r = PT_R_WRIST;
            default: r = PT_L_ELBOW;
        endcase
        return r;
    endfunction

    // Rounded atan(2^-i) in units of 1/65536 degree.
    function automatic ang_t atan_entry(input logic [4:0] i);
        ang_t r;
        case (i)
            5'd0:    r = ANG_W'(2949120);
            5'd1:    r = ANG_W'(1740967);
            5'd2:    r = ANG_W'(919879);
            5'd3:    r = ANG_W'(466945);
            5'd4:    r = ANG_W'(234379);
            5'd5:    r = ANG_W'(117304);
            5'd6:    r = ANG_W'(58666);
            5'd7:    r = ANG_W'(29335);
            5'd8:    r = ANG_W'(14668);
            5'd9:    r = ANG_W'(7334);
            5'd10:   r = ANG_W'(3667);
            5'd11:   r = ANG_W'(1833);
            5'd12:   r = ANG_W'(917);
            5'd13:   r = ANG_W'(458);
            5'd14:   r = ANG_W'(229);
            5'd15:   r = ANG_W'(115);
            5'd16:   r = ANG_W'(57);
            5'd17:   r = ANG_W'(29);
            5'd18:   r = ANG_W'(14);
            5'd19:   r = ANG_W'(7);
            5'd20:   r = ANG_W'(4);
            5'd21:   r = ANG_W'(2);
            5'd22:   r = ANG_W'(1);
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic ang_t ang_abs(input ang_t a);
        return a[ANG_W-1] ? -a : a;
    endfunction

    function automatic logic arm_up(input ang_t s, input ang_t e);
        return (s > LIM_90) && (s < LIM_140) && (ang_abs(e) > LIM_100);
    endfunction

    function automatic logic elbow_up(input ang_t s, input ang_t e);
        ang_t m;
        m = ang_abs(s);
        return (m >= LIM_160) && (m < LIM_181) && (e >= LIM_70) && (e < LIM_110);
    endfunction

endpackage

[hw/rtl/pose_gesture_classifier_core.sv]
// Top level of the pose gesture classifier: keypoint store, sequencer and result register.
// Items are accepted only while the sequencer is idle. An item with last starts four angle
// evaluations in turn on one shared multiplier and CORDIC; an angle with a missing point
// skips both and gives zero. The result is then loaded once the output register is free.
// Reset clears the presence flags, the sequencer and the result valid; coordinates are not reset.
module pose_gesture_classifier_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [pgc_pkg::IDX_W-1:0]   s_point_index,
    input  logic [pgc_pkg::FIELD_W-1:0] s_pos_x,
    input  logic [pgc_pkg::FIELD_W-1:0] s_pos_y,
    input  logic                        s_present,
    input  logic                        s_last,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_left_arm_up,
    output logic                        m_right_arm_up,
    output logic                        m_left_elbow_up,
    output logic                        m_right_elbow_up
);

    localparam logic [2:0] T_IDLE  = 3'd0;
    localparam logic [2:0] T_RDB   = 3'd1;
    localparam logic [2:0] T_RDA   = 3'd2;
    localparam logic [2:0] T_RDC   = 3'd3;
    localparam logic [2:0] T_START = 3'd4;
    localparam logic [2:0] T_WAIT  = 3'd5;
    localparam logic [2:0] T_OUT   = 3'd6;

    logic [2:0]                         state_reg, state_next;
    logic [1:0]                         k_reg, k_next;
    logic [pgc_pkg::NUM_POINTS-1:0]     pres_reg, pres_next;
    logic                               m_valid_reg, m_valid_next;
    pgc_pkg::coord_t                    x_store_reg [pgc_pkg::NUM_POINTS];
    pgc_pkg::coord_t                    y_store_reg [pgc_pkg::NUM_POINTS];
    pgc_pkg::coord_t                    bx_reg, by_reg;
    pgc_pkg::diff_t                     ux_reg, uy_reg, vx_reg, vy_reg;
    pgc_pkg::ang_t                      ang_reg [4];
    logic                               lau_reg, rau_reg, leu_reg, reu_reg;

    logic                               s_fire, out_load;
    logic [pgc_pkg::IDX_W-1:0]          rd_idx;
    pgc_pkg::coord_t                    rd_x, rd_y;
    pgc_pkg::diff_t                     diff_x, diff_y;
    pgc_pkg::ang_req_t                  ang_req;
    pgc_pkg::ang_rsp_t                  ang_rsp;
    pgc_pkg::ang_t                      ang_val;

    assign s_ready  = (state_reg == T_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_load = (state_reg == T_OUT) && (!m_valid_reg || m_ready);

    always_comb begin
        case (state_reg)
            T_RDB:   rd_idx = pgc_pkg::pt_b(k_reg);
            T_RDA:   rd_idx = pgc_pkg::pt_a(k_reg);
            default: rd_idx = pgc_pkg::pt_c(k_reg);
        endcase
    end

    assign rd_x   = x_store_reg[rd_idx];
    assign rd_y   = y_store_reg[rd_idx];
    assign diff_x = $signed({1'b0, rd_x}) - $signed({1'b0, bx_reg});
    assign diff_y = $signed({1'b0, rd_y}) - $signed({1'b0, by_reg});

    assign ang_req.start   = (state_reg == T_START);
    assign ang_req.missing = !(pres_reg[pgc_pkg::pt_a(k_reg)] && pres_reg[pgc_pkg::pt_b(k_reg)]
                               && pres_reg[pgc_pkg::pt_c(k_reg)]);

    pgc_angle_unit u_angle (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ang_req),
        .ux      (ux_reg),
        .uy      (uy_reg),
        .vx      (vx_reg),
        .vy      (vy_reg),
        .rsp     (ang_rsp),
        .angle   (ang_val)
    );

    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        pres_next    = pres_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            T_IDLE: begin
                k_next = '0;
                if (s_fire) begin
                    if (s_point_index < pgc_pkg::IDX_W'(pgc_pkg::NUM_POINTS)) begin
                        pres_next[s_point_index] = s_present;
                    end
                    if (s_last) begin
                        state_next = T_RDB;
                    end
                end
            end
            T_RDB:   state_next = T_RDA;
            T_RDA:   state_next = T_RDC;
            T_RDC:   state_next = T_START;
            T_START: state_next = T_WAIT;
            T_WAIT: begin
                if (ang_rsp.done) begin
                    k_next     = k_reg + 2'd1;
                    state_next = (k_reg == pgc_pkg::ANG_ER) ? T_OUT : T_RDB;
                end
            end
            T_OUT: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    pres_next    = '0;
                    state_next   = T_IDLE;
                end
            end
            default: begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_IDLE;
            k_reg       <= '0;
            pres_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            pres_reg    <= pres_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && (s_point_index < pgc_pkg::IDX_W'(pgc_pkg::NUM_POINTS))) begin
            x_store_reg[s_point_index] <= pgc_pkg::COORD_WIDTH'(s_pos_x);
            y_store_reg[s_point_index] <= pgc_pkg::COORD_WIDTH'(s_pos_y);
        end
        if (state_reg == T_RDB) begin
            bx_reg <= rd_x;
            by_reg <= rd_y;
        end
        if (state_reg == T_RDA) begin
            ux_reg <= diff_x;
            uy_reg <= diff_y;
        end
        if (state_reg == T_RDC) begin
            vx_reg <= diff_x;
            vy_reg <= diff_y;
        end
        if ((state_reg == T_WAIT) && ang_rsp.done) begin
            ang_reg[k_reg] <= ang_val;
        end
        if (out_load) begin
            lau_reg <= pgc_pkg::arm_up(ang_reg[pgc_pkg::ANG_SL], ang_reg[pgc_pkg::ANG_EL]);
            rau_reg <= pgc_pkg::arm_up(-ang_reg[pgc_pkg::ANG_SR], ang_reg[pgc_pkg::ANG_ER]);
            leu_reg <= pgc_pkg::elbow_up(ang_reg[pgc_pkg::ANG_SL], ang_reg[pgc_pkg::ANG_EL]);
            reu_reg <= pgc_pkg::elbow_up(ang_reg[pgc_pkg::ANG_SR], -ang_reg[pgc_pkg::ANG_ER]);
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_left_arm_up    = lau_reg;
    assign m_right_arm_up   = rau_reg;
    assign m_left_elbow_up  = leu_reg;
    assign m_right_elbow_up = reu_reg;

    // The presence flags are all clear once a result has been loaded.
    a_pres_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (pres_reg == '0))
        else $error("presence flags not cleared after a result");

    // The angle unit only finishes while the sequencer is waiting for it.
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        ang_rsp.done |-> (state_reg == T_WAIT))
        else $error("angle unit finished outside the wait state");

    // A new evaluation never starts while the angle unit is still busy.
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ang_req.start |-> !ang_rsp.busy)
        else $error("angle evaluation started while the unit was busy");

    // A result appears only after all four angles are done.
    a_rose_after_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == T_OUT) && ($past(k_reg) == pgc_pkg::ANG_SL))
        else $error("result valid without a completed pose");

endmodule

[hw/rtl/pgc_angle_unit.sv]
// Shared multiplier and iterative CORDIC that turn two vectors into a vertex angle.
module pgc_angle_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  pgc_pkg::ang_req_t req,
    input  pgc_pkg::diff_t    ux,
    input  pgc_pkg::diff_t    uy,
    input  pgc_pkg::diff_t    vx,
    input  pgc_pkg::diff_t    vy,
    output pgc_pkg::ang_rsp_t rsp,
    output pgc_pkg::ang_t     angle
);

    localparam logic [2:0] A_IDLE = 3'd0;
    localparam logic [2:0] A_MUL  = 3'd1;
    localparam logic [2:0] A_PRE  = 3'd2;
    localparam logic [2:0] A_ITER = 3'd3;
    localparam logic [2:0] A_DONE = 3'd4;

    logic [2:0]                        state_reg, state_next;
    logic [2:0]                        cnt_reg, cnt_next;
    logic [pgc_pkg::STEP_W-1:0]        step_reg, step_next;
    logic signed [pgc_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic signed [pgc_pkg::CW-1:0]     x_reg, x_next;
    logic signed [pgc_pkg::CW-1:0]     y_reg, y_next;
    pgc_pkg::ang_t                     z_reg, z_next;

    pgc_pkg::diff_t                    mul_a, mul_b;
    logic signed [pgc_pkg::CW-1:0]     prod_ext, dx, dy;
    pgc_pkg::ang_t                     tab;

    assign prod_ext = pgc_pkg::CW'(prod_reg);
    assign dx       = y_reg >>> step_reg;
    assign dy       = x_reg >>> step_reg;
    assign tab      = pgc_pkg::atan_entry(5'(step_reg));

    always_comb begin
        case (cnt_reg[1:0])
            2'd0:    begin mul_a = ux; mul_b = vy; end
            2'd1:    begin mul_a = uy; mul_b = vx; end
            2'd2:    begin mul_a = ux; mul_b = vx; end
            default: begin mul_a = uy; mul_b = vy; end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        step_next  = step_reg;
        prod_next  = pgc_pkg::PROD_W'(mul_a) * pgc_pkg::PROD_W'(mul_b);
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        case (state_reg)
            A_IDLE: begin
                cnt_next = '0;
                if (req.start) begin
                    if (req.missing) begin
                        z_next     = '0;
                        state_next = A_DONE;
                    end else begin
                        state_next = A_MUL;
                    end
                end
            end
            A_MUL: begin
                cnt_next = cnt_reg + 3'd1;
                case (cnt_reg)
                    3'd1:    y_next = prod_ext;
                    3'd2:    y_next = y_reg - prod_ext;
                    3'd3:    x_next = prod_ext;
                    3'd4:    x_next = x_reg + prod_ext;
                    default: ;
                endcase
                if (cnt_reg == 3'd4) begin
                    state_next = A_PRE;
                end
            end
            A_PRE: begin
                step_next = '0;
                if (y_reg == '0) begin
                    z_next     = x_reg[pgc_pkg::CW-1] ? pgc_pkg::LIM_180 : '0;
                    state_next = A_DONE;
                end else if (x_reg == '0) begin
                    z_next     = y_reg[pgc_pkg::CW-1] ? -pgc_pkg::LIM_90 : pgc_pkg::LIM_90;
                    state_next = A_DONE;
                end else if (x_reg[pgc_pkg::CW-1]) begin
                    z_next     = y_reg[pgc_pkg::CW-1] ? -pgc_pkg::LIM_180 : pgc_pkg::LIM_180;
                    x_next     = -x_reg;
                    y_next     = -y_reg;
                    state_next = A_ITER;
                end else begin
                    z_next     = '0;
                    state_next = A_ITER;
                end
            end
            A_ITER: begin
                step_next = step_reg + pgc_pkg::STEP_W'(1);
                if (!y_reg[pgc_pkg::CW-1]) begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + tab;
                end else begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - tab;
                end
                if (step_reg == pgc_pkg::STEP_W'(pgc_pkg::CORDIC_STEPS - 1)) begin
                    state_next = A_DONE;
                end
            end
            A_DONE: begin
                state_next = A_IDLE;
            end
            default: begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
            cnt_reg   <= '0;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
    end

    assign rsp.done = (state_reg == A_DONE);
    assign rsp.busy = (state_reg != A_IDLE);
    assign angle    = z_reg;

endmodule

[bench/pgc_bench_pkg.sv]
// Keypoint codes shared by the pose gesture classifier testbench files.
package pgc_bench_pkg;

    typedef enum logic [2:0] {
        KP_NECK,
        KP_L_SHOULDER,
        KP_L_ELBOW,
        KP_L_WRIST,
        KP_R_SHOULDER,
        KP_R_ELBOW,
        KP_R_WRIST,
        KP_UNUSED
    } keypoint_e;

endpackage

[bench/pgc_gesture_checker.sv]
// Checker that predicts the gesture flags of each pose and compares them with the results.
module pgc_gesture_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic [pgc_pkg::IDX_W-1:0]   s_point_index,
    input  logic [pgc_pkg::FIELD_W-1:0] s_pos_x,
    input  logic [pgc_pkg::FIELD_W-1:0] s_pos_y,
    input  logic                        s_present,
    input  logic                        s_last,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic                        m_left_arm_up,
    input  logic                        m_right_arm_up,
    input  logic                        m_left_elbow_up,
    input  logic                        m_right_elbow_up,
    output int                          fail_count,
    output int                          poses_pending
);

    localparam longint DEG_UNITS = 65536;
    localparam int     ATAN_STEPS_MAX = 24;

    typedef struct packed {
        logic left_arm_up;
        logic right_arm_up;
        logic left_elbow_up;
        logic right_elbow_up;
    } gestures_t;

    longint atan_units [0:ATAN_STEPS_MAX-1] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    pgc_pkg::coord_t kp_x       [pgc_pkg::NUM_POINTS];
    pgc_pkg::coord_t kp_y       [pgc_pkg::NUM_POINTS];
    logic            kp_present [pgc_pkg::NUM_POINTS];
    gestures_t       expected_gestures [$];

    // Vectoring rotation; angles are in 1/65536 degree and shifts round toward minus infinity.
    function automatic longint cordic_atan2(input longint cross_in, input longint dot_in);
        longint x, y, z, dx, dy;
        int i;
        x = dot_in;
        y = cross_in;
        z = 0;
        if (y == 0) return (x >= 0) ? 0 : 180 * DEG_UNITS;
        if (x == 0) return (y > 0) ? 90 * DEG_UNITS : -90 * DEG_UNITS;
        if (x < 0) begin
            z = (y > 0) ? 180 * DEG_UNITS : -180 * DEG_UNITS;
            x = -x;
            y = -y;
        end
        for (i = 0; i < pgc_pkg::CORDIC_STEPS && i < ATAN_STEPS_MAX; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx;
                y = y - dy;
                z = z + atan_units[i];
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - atan_units[i];
            end
        end
        return z;
    endfunction

    function automatic longint vertex_angle(input pgc_bench_pkg::keypoint_e a,
                                            input pgc_bench_pkg::keypoint_e b,
                                            input pgc_bench_pkg::keypoint_e c);
        longint ux, uy, vx, vy;
        if (!(kp_present[a] && kp_present[b] && kp_present[c])) return 0;
        ux = longint'(kp_x[a]) - longint'(kp_x[b]);
        uy = longint'(kp_y[a]) - longint'(kp_y[b]);
        vx = longint'(kp_x[c]) - longint'(kp_x[b]);
        vy = longint'(kp_y[c]) - longint'(kp_y[b]);
        return cordic_atan2(ux * vy - uy * vx, ux * vx + uy * vy);
    endfunction

    function automatic logic arm_raised(input longint s_ang, input longint e_ang);
        longint e_mag;
        e_mag = (e_ang < 0) ? -e_ang : e_ang;
        return (s_ang > 90 * DEG_UNITS) && (s_ang < 140 * DEG_UNITS) &&
               (e_mag > 100 * DEG_UNITS);
    endfunction

    function automatic logic elbow_raised(input longint s_ang, input longint e_ang);
        longint s_mag;
        s_mag = (s_ang < 0) ? -s_ang : s_ang;
        return (s_mag >= 160 * DEG_UNITS) && (s_mag < 181 * DEG_UNITS) &&
               (e_ang >= 70 * DEG_UNITS) && (e_ang < 110 * DEG_UNITS);
    endfunction

    function automatic gestures_t predict_gestures();
        longint sl, el, sr, er;
        gestures_t g;
        sl = vertex_angle(pgc_bench_pkg::KP_NECK, pgc_bench_pkg::KP_L_SHOULDER,
                          pgc_bench_pkg::KP_L_ELBOW);
        el = vertex_angle(pgc_bench_pkg::KP_L_SHOULDER, pgc_bench_pkg::KP_L_ELBOW,
                          pgc_bench_pkg::KP_L_WRIST);
        sr = vertex_angle(pgc_bench_pkg::KP_NECK, pgc_bench_pkg::KP_R_SHOULDER,
                          pgc_bench_pkg::KP_R_ELBOW);
        er = vertex_angle(pgc_bench_pkg::KP_R_SHOULDER, pgc_bench_pkg::KP_R_ELBOW,
                          pgc_bench_pkg::KP_R_WRIST);
        g.left_arm_up    = arm_raised(sl, el);
        g.right_arm_up   = arm_raised(-sr, er);
        g.left_elbow_up  = elbow_raised(sl, el);
        g.right_elbow_up = elbow_raised(sr, -er);
        return g;
    endfunction

    function automatic void check_flag(input string name, input logic want, input logic got);
        if (want !== got) begin
            $error("%s: expected %0b, actual %0b", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin : monitor
        gestures_t want;
        int k;
        if (!aresetn) begin
            for (k = 0; k < pgc_pkg::NUM_POINTS; k++) kp_present[k] = 1'b0;
            expected_gestures.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_gestures.size() == 0) begin
                    $error("gesture result arrived with no pose pending");
                    fail_count++;
                end else begin
                    want = expected_gestures.pop_front();
                    check_flag("left_arm_up", want.left_arm_up, m_left_arm_up);
                    check_flag("right_arm_up", want.right_arm_up, m_right_arm_up);
                    check_flag("left_elbow_up", want.left_elbow_up, m_left_elbow_up);
                    check_flag("right_elbow_up", want.right_elbow_up, m_right_elbow_up);
                end
            end
            if (s_valid && s_ready) begin
                if (s_point_index < pgc_pkg::NUM_POINTS) begin
                    kp_x[s_point_index]       = s_pos_x[pgc_pkg::COORD_WIDTH-1:0];
                    kp_y[s_point_index]       = s_pos_y[pgc_pkg::COORD_WIDTH-1:0];
                    kp_present[s_point_index] = s_present;
                end
                if (s_last) begin
                    expected_gestures.push_back(predict_gestures());
                    for (k = 0; k < pgc_pkg::NUM_POINTS; k++) kp_present[k] = 1'b0;
                end
            end
        end
        poses_pending = expected_gestures.size();
    end

endmodule

[bench/pose_gesture_classifier_core_test.sv]
// Testbench top of the pose gesture classifier: clock, reset, pose stimulus and verdict.
module pose_gesture_classifier_core_test;

    localparam int  ITEM_TARGET     = 1950;
    localparam int  STALL_LIMIT     = 3000;
    localparam int  HOLD_OFF_AT     = 30;
    localparam int  HOLD_OFF_CYCLES = 400;
    localparam int  DRAIN_CYCLES    = 150;
    localparam real DEG_TO_RAD      = 3.14159265358979 / 180.0;

    logic                        aclk;
    logic                        aresetn = 1'b0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic [pgc_pkg::IDX_W-1:0]   s_point_index = '0;
    logic [pgc_pkg::FIELD_W-1:0] s_pos_x = '0;
    logic [pgc_pkg::FIELD_W-1:0] s_pos_y = '0;
    logic                        s_present = 1'b0;
    logic                        s_last = 1'b0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic                        m_left_arm_up;
    logic                        m_right_arm_up;
    logic                        m_left_elbow_up;
    logic                        m_right_elbow_up;

    int fail_count;
    int poses_pending;
    int quiet_cycles = 0;
    int items_sent = 0;
    int results_taken = 0;
    bit sender_calm = 1'b0;

    pgc_pkg::coord_t pose_x       [pgc_pkg::NUM_POINTS];
    pgc_pkg::coord_t pose_y       [pgc_pkg::NUM_POINTS];
    logic            pose_present [pgc_pkg::NUM_POINTS];

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    pose_gesture_classifier_core u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_point_index    (s_point_index),
        .s_pos_x          (s_pos_x),
        .s_pos_y          (s_pos_y),
        .s_present        (s_present),
        .s_last           (s_last),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_left_arm_up    (m_left_arm_up),
        .m_right_arm_up   (m_right_arm_up),
        .m_left_elbow_up  (m_left_elbow_up),
        .m_right_elbow_up (m_right_elbow_up)
    );

    pgc_gesture_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_point_index    (s_point_index),
        .s_pos_x          (s_pos_x),
        .s_pos_y          (s_pos_y),
        .s_present        (s_present),
        .s_last           (s_last),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_left_arm_up    (m_left_arm_up),
        .m_right_arm_up   (m_right_arm_up),
        .m_left_elbow_up  (m_left_elbow_up),
        .m_right_elbow_up (m_right_elbow_up),
        .fail_count       (fail_count),
        .poses_pending    (poses_pending)
    );

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input pgc_bench_pkg::keypoint_e idx, input pgc_pkg::coord_t x,
                             input pgc_pkg::coord_t y, input logic present, input logic last);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_point_index <= idx;
        s_pos_x       <= x;
        s_pos_y       <= y;
        s_present     <= present;
        s_last        <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
        if (items_sent % 40 == 0) sender_calm = ($urandom_range(0, 3) == 0);
    endtask

    task automatic send_pose(input bit shuffled);
        pgc_bench_pkg::keypoint_e order [pgc_pkg::NUM_POINTS];
        pgc_bench_pkg::keypoint_e t;
        int j, k;
        for (k = 0; k < pgc_pkg::NUM_POINTS; k++) order[k] = pgc_bench_pkg::keypoint_e'(k);
        if (shuffled) begin
            for (k = pgc_pkg::NUM_POINTS - 1; k > 0; k--) begin
                j = $urandom_range(0, k);
                t = order[k];
                order[k] = order[j];
                order[j] = t;
            end
        end
        for (k = 0; k < pgc_pkg::NUM_POINTS; k++) begin
            send_item(order[k], pose_x[order[k]], pose_y[order[k]], pose_present[order[k]],
                      k == pgc_pkg::NUM_POINTS - 1);
        end
    endtask

    task automatic send_noise();
        int n, k;
        n = $urandom_range(1, 9);
        for (k = 0; k < n; k++) begin
            send_item(pgc_bench_pkg::keypoint_e'($urandom_range(0, 7)),
                      pgc_pkg::coord_t'($urandom_range(0, 65535)),
                      pgc_pkg::coord_t'($urandom_range(0, 65535)),
                      1'($urandom_range(0, 1)), $urandom_range(0, 5) == 0);
        end
    endtask

    task automatic set_point(input pgc_bench_pkg::keypoint_e kp, input int x, input int y,
                             input logic p);
        pose_x[kp]       = pgc_pkg::coord_t'(x);
        pose_y[kp]       = pgc_pkg::coord_t'(y);
        pose_present[kp] = p;
    endtask

    function automatic real rand_span(input int half);
        int v;
        v = $urandom_range(0, 2 * half);
        return $itor(v - half);
    endfunction

    function automatic pgc_pkg::coord_t to_coord(input real v);
        if (v < 0.0) return '0;
        if (v > 65535.0) return '1;
        return pgc_pkg::coord_t'($rtoi(v + 0.5));
    endfunction

    // Angles cluster around the gesture bounds so that every flag is both set and cleared.
    function automatic real pick_angle();
        real center;
        int jitter;
        case ($urandom_range(0, 10))
            0:       return $itor($urandom_range(0, 360000)) * 0.001 - 180.0;
            1:       center = 0.0;
            2:       center = 70.0;
            3:       center = 90.0;
            4:       center = 100.0;
            5:       center = 110.0;
            6:       center = 115.0;
            7:       center = 140.0;
            8:       center = 160.0;
            9:       center = 170.0;
            default: center = 180.0;
        endcase
        jitter = $urandom_range(0, 4000);
        jitter = jitter - 2000;
        center = center + $itor(jitter) * 0.001;
        return ($urandom_range(0, 1) == 1) ? center : -center;
    endfunction

    task automatic place_limb(input real ax, input real ay, input real bx, input real by,
                              input real angle_deg, input real length,
                              output real cx, output real cy);
        real ux, uy, norm, cs, sn;
        ux = ax - bx;
        uy = ay - by;
        norm = $sqrt(ux * ux + uy * uy);
        if (norm < 1.0) begin
            ux = 1.0;
            uy = 0.0;
            norm = 1.0;
        end
        ux = ux / norm;
        uy = uy / norm;
        cs = $cos(angle_deg * DEG_TO_RAD);
        sn = $sin(angle_deg * DEG_TO_RAD);
        cx = bx + length * (ux * cs - uy * sn);
        cy = by + length * (ux * sn + uy * cs);
    endtask

    task automatic build_pose(input real sl_deg, input real el_deg, input real sr_deg,
                              input real er_deg, input bit all_present);
        real nx, ny, lsx, lsy, lex, ley, lwx, lwy, rsx, rsy, rex, rey, rwx, rwy;
        int k;
        nx  = 32768.0 + rand_span(4000);
        ny  = 20000.0 + rand_span(4000);
        lsx = nx + 1000.0 + $itor($urandom_range(0, 5000));
        lsy = ny + rand_span(800);
        rsx = nx - 1000.0 - $itor($urandom_range(0, 5000));
        rsy = ny + rand_span(800);
        place_limb(nx, ny, lsx, lsy, sl_deg, $itor($urandom_range(300, 9000)), lex, ley);
        place_limb(lsx, lsy, lex, ley, el_deg, $itor($urandom_range(300, 9000)), lwx, lwy);
        place_limb(nx, ny, rsx, rsy, sr_deg, $itor($urandom_range(300, 9000)), rex, rey);
        place_limb(rsx, rsy, rex, rey, er_deg, $itor($urandom_range(300, 9000)), rwx, rwy);
        pose_x[pgc_bench_pkg::KP_NECK]       = to_coord(nx);
        pose_y[pgc_bench_pkg::KP_NECK]       = to_coord(ny);
        pose_x[pgc_bench_pkg::KP_L_SHOULDER] = to_coord(lsx);
        pose_y[pgc_bench_pkg::KP_L_SHOULDER] = to_coord(lsy);
        pose_x[pgc_bench_pkg::KP_L_ELBOW]    = to_coord(lex);
        pose_y[pgc_bench_pkg::KP_L_ELBOW]    = to_coord(ley);
        pose_x[pgc_bench_pkg::KP_L_WRIST]    = to_coord(lwx);
        pose_y[pgc_bench_pkg::KP_L_WRIST]    = to_coord(lwy);
        pose_x[pgc_bench_pkg::KP_R_SHOULDER] = to_coord(rsx);
        pose_y[pgc_bench_pkg::KP_R_SHOULDER] = to_coord(rsy);
        pose_x[pgc_bench_pkg::KP_R_ELBOW]    = to_coord(rex);
        pose_y[pgc_bench_pkg::KP_R_ELBOW]    = to_coord(rey);
        pose_x[pgc_bench_pkg::KP_R_WRIST]    = to_coord(rwx);
        pose_y[pgc_bench_pkg::KP_R_WRIST]    = to_coord(rwy);
        for (k = 0; k < pgc_pkg::NUM_POINTS; k++) begin
            pose_present[k] = all_present ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    endtask

    initial begin : result_sink
        int gap;
        bit calm;
        calm = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if (results_taken == HOLD_OFF_AT) begin
                gap = HOLD_OFF_CYCLES;
            end else begin
                gap = calm ? 0 : $urandom_range(0, 11);
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            @(negedge aclk);
            results_taken++;
            if (results_taken % 8 == 0) calm = ($urandom_range(0, 3) == 0);
        end
    end

    initial begin : watchdog
        while (quiet_cycles < STALL_LIMIT) @(negedge aclk);
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Coordinate extremes; the left shoulder angle lands exactly on minus ninety degrees, the right on plus ninety.
        set_point(pgc_bench_pkg::KP_NECK, 0, 0, 1'b1);
        set_point(pgc_bench_pkg::KP_L_SHOULDER, 65535, 0, 1'b1);
        set_point(pgc_bench_pkg::KP_L_ELBOW, 65535, 65535, 1'b1);
        set_point(pgc_bench_pkg::KP_L_WRIST, 0, 65535, 1'b1);
        set_point(pgc_bench_pkg::KP_R_SHOULDER, 0, 65535, 1'b1);
        set_point(pgc_bench_pkg::KP_R_ELBOW, 65535, 65535, 1'b1);
        set_point(pgc_bench_pkg::KP_R_WRIST, 65535, 0, 1'b1);
        send_pose(1'b0);

        // Collinear and coincident points give exactly zero or one hundred eighty degrees.
        set_point(pgc_bench_pkg::KP_NECK, 1000, 1000, 1'b1);
        set_point(pgc_bench_pkg::KP_L_SHOULDER, 2000, 1000, 1'b1);
        set_point(pgc_bench_pkg::KP_L_ELBOW, 3000, 1000, 1'b1);
        set_point(pgc_bench_pkg::KP_L_WRIST, 2000, 1000, 1'b1);
        set_point(pgc_bench_pkg::KP_R_SHOULDER, 1000, 1000, 1'b1);
        set_point(pgc_bench_pkg::KP_R_ELBOW, 1000, 5000, 1'b1);
        set_point(pgc_bench_pkg::KP_R_WRIST, 1000, 9000, 1'b1);
        send_pose(1'b1);

        // A partial pose with a missing keypoint, closed by the unused index.
        send_item(pgc_bench_pkg::KP_NECK, 16'd100, 16'd200, 1'b1, 1'b0);
        send_item(pgc_bench_pkg::KP_L_SHOULDER, 16'd300, 16'd400, 1'b1, 1'b0);
        send_item(pgc_bench_pkg::KP_L_ELBOW, 16'd500, 16'd100, 1'b0, 1'b0);
        send_item(pgc_bench_pkg::KP_UNUSED, 16'hffff, 16'hffff, 1'b1, 1'b1);

        build_pose(115.0, 150.0, -115.0, -150.0, 1'b1);
        send_pose(1'b0);

        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 9) < 8) begin
                build_pose(pick_angle(), pick_angle(), pick_angle(), pick_angle(),
                           $urandom_range(0, 4) != 0);
                send_pose($urandom_range(0, 3) != 0);
            end else begin
                send_noise();
            end
        end
        s_valid <= 1'b0;

        while (poses_pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
